// ----- design/drl_pkg.sv -----
// Shared types and constants of the DDA line rasterizer.
// Used by the front classifier, the item queue, the back end and the top level.
`default_nettype none
package drl_pkg;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    localparam logic CFG_WINDOW_WIDTH  = 1'b0;
    localparam logic CFG_WINDOW_HEIGHT = 1'b1;

    localparam logic [14:0] WIDTH_RESET  = 15'd1920;
    localparam logic [14:0] HEIGHT_RESET = 15'd1080;

    // Root digits produced by the square root unit (50-bit radicand).
    localparam int SQRT_ITERS = 25;
    localparam logic [15:0] MAX_STEPS = 16'hFFFF;

    typedef struct packed {
        logic               action;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [24:0] delta_x;
        logic signed [24:0] delta_y;
        logic [31:0]        colour;
    } drl_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT,
        ST_SETUP,
        ST_DIV,
        ST_RESULT
    } drl_state_t;

endpackage
`default_nettype wire

// ----- design/dda_line_rasterizer.sv -----
// Top level of the DDA line rasterizer: configuration registers, front, queue and back end.
// Depends on drl_pkg, drl_front, drl_queue and drl_back.
//
// Every input transfer produces exactly one result transfer. A load item (action 0) latches
// a start point, the deltas to the end point and a colour; the back end then squares the
// deltas, extracts the integer square root one digit per cycle, and divides both scaled
// deltas by the step count in two parallel restoring dividers, one quotient bit per cycle.
// A tick item (action 1) yields one result, a pixel while the line has steps left, so a
// loaded line streams one pixel per clock while ticks arrive and the receiver accepts.
// A two-entry queue lets the input side keep accepting while the back end is busy, and
// the result register lets the next load item be taken while a result waits. The window
// registers are written through the plain write port and should only be changed while
// the block is idle.
`default_nettype none
module dda_line_rasterizer import drl_pkg::*; #(
    parameter int POSITION_FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [14:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic signed [23:0] s_start_x,
    input  wire logic signed [23:0] s_start_y,
    input  wire logic signed [23:0] s_end_x,
    input  wire logic signed [23:0] s_end_y,
    input  wire logic [31:0]        s_line_colour,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_pixel_x,
    output logic signed [15:0]      m_pixel_y,
    output logic [31:0]             m_pixel_colour,
    output logic                    m_pixel_write,
    output logic                    m_line_last,
    output logic                    m_line_busy
);

    logic [14:0] width_reg, width_next;
    logic [14:0] height_reg, height_next;
    drl_item_t   front_item;
    drl_item_t   q_item;
    logic        q_valid;
    logic        q_pop;

    // Window registers hold the exclusive upper bounds of the drawn area.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write) begin
            case (cfg_index)
                CFG_WINDOW_WIDTH:  width_next  = cfg_data;
                CFG_WINDOW_HEIGHT: height_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    drl_front u_front (
        .action      (s_action),
        .start_x     (s_start_x),
        .start_y     (s_start_y),
        .end_x       (s_end_x),
        .end_y       (s_end_y),
        .line_colour (s_line_colour),
        .item        (front_item)
    );

    drl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    drl_back #(
        .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .window_width   (width_reg),
        .window_height  (height_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_colour (m_pixel_colour),
        .m_pixel_write  (m_pixel_write),
        .m_line_last    (m_line_last),
        .m_line_busy    (m_line_busy)
    );

endmodule
`default_nettype wire

// ----- design/drl_front.sv -----
// Front classifier: turns an incoming transfer into a queue item with endpoint deltas.
// Depends on drl_pkg.
`default_nettype none
module drl_front import drl_pkg::*; (
    input  wire logic               action,
    input  wire logic signed [23:0] start_x,
    input  wire logic signed [23:0] start_y,
    input  wire logic signed [23:0] end_x,
    input  wire logic signed [23:0] end_y,
    input  wire logic [31:0]        line_colour,
    output drl_item_t               item
);

    always_comb begin
        item.action  = action;
        item.start_x = start_x;
        item.start_y = start_y;
        item.delta_x = 25'(signed'(end_x)) - 25'(signed'(start_x));
        item.delta_y = 25'(signed'(end_y)) - 25'(signed'(start_y));
        item.colour  = line_colour;
    end

endmodule
`default_nettype wire

// ----- design/drl_queue.sv -----
// Two-entry item queue between the front classifier and the back end.
// Depends on drl_pkg.
`default_nettype none
module drl_queue import drl_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire drl_item_t in_item,
    output logic           out_valid,
    input  wire logic      out_pop,
    output drl_item_t      out_item
);

    drl_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ----- design/drl_back.sv -----
// Back end: square root and division for loads, pixel stepping for ticks, result register.
// Depends on drl_pkg.
`default_nettype none
module drl_back import drl_pkg::*; #(
    parameter int POSITION_FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    input  wire drl_item_t    q_item,
    output logic              q_pop,
    input  wire logic [14:0]  window_width,
    input  wire logic [14:0]  window_height,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [15:0]       m_pixel_x,
    output logic [15:0]       m_pixel_y,
    output logic [31:0]       m_pixel_colour,
    output logic              m_pixel_write,
    output logic              m_line_last,
    output logic              m_line_busy
);

    localparam int F  = POSITION_FRAC_BITS;
    localparam int PW = F + 16;
    localparam int IW = F + 2;
    localparam int CW = $clog2(PW);

    drl_state_t state_reg, state_next;

    logic signed [PW-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [IW-1:0] inc_x_reg, inc_x_next, inc_y_reg, inc_y_next;
    logic [15:0]          steps_reg, steps_next;
    logic [31:0]          colour_reg, colour_next;
    logic [23:0]          mag_x_reg, mag_x_next, mag_y_reg, mag_y_next;
    logic                 neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [49:0]          sum_reg, sum_next;
    logic [27:0]          rem_reg, rem_next;
    logic [24:0]          root_reg, root_next;
    logic [CW-1:0]        iter_reg, iter_next;
    logic [15:0]          cnt_reg, cnt_next;
    logic [PW-1:0]        num_x_reg, num_x_next, num_y_reg, num_y_next;
    logic [15:0]          dr_x_reg, dr_x_next, dr_y_reg, dr_y_next;

    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [31:0]          out_colour_reg, out_colour_next;
    logic                 out_write_reg, out_write_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_busy_reg, out_busy_next;

    logic                 out_free;
    logic                 is_tick;

    // Combinational helpers.
    logic [47:0]          sq_x, sq_y;
    logic [27:0]          rem_try, trial;
    logic [16:0]          root_len;
    logic [15:0]          cnt_calc;
    logic [16:0]          dt_x, dt_y;
    logic                 qb_x, qb_y;
    logic [PW-1:0]        mag_pos_x, mag_pos_y;
    logic [15:0]          ip_x, ip_y;
    logic                 in_x, in_y;

    assign out_free = !out_valid_reg || m_ready;
    assign is_tick  = (q_item.action == ACTION_TICK);

    always_comb begin
        sq_x     = mag_x_reg * mag_x_reg;
        sq_y     = mag_y_reg * mag_y_reg;
        rem_try  = {rem_reg[25:0], sum_reg[49:48]};
        trial    = {1'b0, root_reg, 2'b01};
        root_len = root_reg[24:8];
        cnt_calc = root_len[16] ? MAX_STEPS : root_len[15:0];
        dt_x     = {dr_x_reg, num_x_reg[PW-1]};
        dt_y     = {dr_y_reg, num_y_reg[PW-1]};
        qb_x     = (dt_x >= {1'b0, cnt_reg});
        qb_y     = (dt_y >= {1'b0, cnt_reg});
        mag_pos_x = pos_x_reg[PW-1] ? PW'(-pos_x_reg) : PW'(pos_x_reg);
        mag_pos_y = pos_y_reg[PW-1] ? PW'(-pos_y_reg) : PW'(pos_y_reg);
        ip_x     = pos_x_reg[PW-1] ? 16'(-mag_pos_x[PW-1:F]) : mag_pos_x[PW-1:F];
        ip_y     = pos_y_reg[PW-1] ? 16'(-mag_pos_y[PW-1:F]) : mag_pos_y[PW-1:F];
        in_x     = !pos_x_reg[PW-1] && (pos_x_reg != '0)
                   && (PW'(pos_x_reg) < {1'b0, window_width, F'(0)});
        in_y     = !pos_y_reg[PW-1] && (pos_y_reg != '0)
                   && (PW'(pos_y_reg) < {1'b0, window_height, F'(0)});
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && !is_tick) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: state_next = ST_SQRT;
            ST_SQRT: begin
                if (iter_reg == '0) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = (cnt_calc == '0) ? ST_RESULT : ST_DIV;
            end
            ST_DIV: begin
                if (iter_reg == '0) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        q_pop           = 1'b0;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        inc_x_next      = inc_x_reg;
        inc_y_next      = inc_y_reg;
        steps_next      = steps_reg;
        colour_next     = colour_reg;
        mag_x_next      = mag_x_reg;
        mag_y_next      = mag_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        sum_next        = sum_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        iter_next       = iter_reg;
        cnt_next        = cnt_reg;
        num_x_next      = num_x_reg;
        num_y_next      = num_y_reg;
        dr_x_next       = dr_x_reg;
        dr_y_next       = dr_y_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_colour_next = out_colour_reg;
        out_write_next  = out_write_reg;
        out_last_next   = out_last_reg;
        out_busy_next   = out_busy_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && !is_tick) begin
                    q_pop       = 1'b1;
                    pos_x_next  = PW'(q_item.start_x) <<< (F - 8);
                    pos_y_next  = PW'(q_item.start_y) <<< (F - 8);
                    colour_next = q_item.colour;
                    neg_x_next  = q_item.delta_x[24];
                    neg_y_next  = q_item.delta_y[24];
                    mag_x_next  = q_item.delta_x[24] ? 24'(-q_item.delta_x)
                                                     : q_item.delta_x[23:0];
                    mag_y_next  = q_item.delta_y[24] ? 24'(-q_item.delta_y)
                                                     : q_item.delta_y[23:0];
                end else if (q_valid && out_free) begin
                    q_pop           = 1'b1;
                    out_valid_next  = 1'b1;
                    if (steps_reg != '0) begin
                        out_x_next      = ip_x;
                        out_y_next      = ip_y;
                        out_colour_next = colour_reg;
                        out_write_next  = in_x && in_y;
                        out_last_next   = (steps_reg == 16'd1);
                        out_busy_next   = (steps_reg != 16'd1);
                        pos_x_next      = pos_x_reg + PW'(inc_x_reg);
                        pos_y_next      = pos_y_reg + PW'(inc_y_reg);
                        steps_next      = steps_reg - 16'd1;
                    end else begin
                        out_x_next      = '0;
                        out_y_next      = '0;
                        out_colour_next = '0;
                        out_write_next  = 1'b0;
                        out_last_next   = 1'b0;
                        out_busy_next   = 1'b0;
                    end
                end
            end
            ST_SQUARE: begin
                sum_next  = {2'b00, sq_x} + {2'b00, sq_y};
                rem_next  = '0;
                root_next = '0;
                iter_next = CW'(SQRT_ITERS - 1);
            end
            ST_SQRT: begin
                // One root digit per cycle, two radicand bits consumed.
                if (rem_try >= trial) begin
                    rem_next  = rem_try - trial;
                    root_next = {root_reg[23:0], 1'b1};
                end else begin
                    rem_next  = rem_try;
                    root_next = {root_reg[23:0], 1'b0};
                end
                sum_next  = {sum_reg[47:0], 2'b00};
                iter_next = iter_reg - 1'b1;
            end
            ST_SETUP: begin
                cnt_next  = cnt_calc;
                dr_x_next = '0;
                dr_y_next = '0;
                iter_next = CW'(PW - 1);
                if (cnt_calc == '0) begin
                    num_x_next = '0;
                    num_y_next = '0;
                end else begin
                    num_x_next = PW'(mag_x_reg) << (F - 8);
                    num_y_next = PW'(mag_y_reg) << (F - 8);
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle in each lane.
                dr_x_next  = qb_x ? 16'(dt_x - {1'b0, cnt_reg}) : dt_x[15:0];
                dr_y_next  = qb_y ? 16'(dt_y - {1'b0, cnt_reg}) : dt_y[15:0];
                num_x_next = {num_x_reg[PW-2:0], qb_x};
                num_y_next = {num_y_reg[PW-2:0], qb_y};
                iter_next  = iter_reg - 1'b1;
            end
            ST_RESULT: begin
                if (out_free) begin
                    inc_x_next      = neg_x_reg ? IW'(-num_x_reg) : num_x_reg[IW-1:0];
                    inc_y_next      = neg_y_reg ? IW'(-num_y_reg) : num_y_reg[IW-1:0];
                    steps_next      = cnt_reg;
                    out_valid_next  = 1'b1;
                    out_x_next      = '0;
                    out_y_next      = '0;
                    out_colour_next = '0;
                    out_write_next  = 1'b0;
                    out_last_next   = 1'b0;
                    out_busy_next   = (cnt_reg != '0);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_x_reg      <= pos_x_next;
        pos_y_reg      <= pos_y_next;
        inc_x_reg      <= inc_x_next;
        inc_y_reg      <= inc_y_next;
        colour_reg     <= colour_next;
        mag_x_reg      <= mag_x_next;
        mag_y_reg      <= mag_y_next;
        neg_x_reg      <= neg_x_next;
        neg_y_reg      <= neg_y_next;
        sum_reg        <= sum_next;
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        iter_reg       <= iter_next;
        cnt_reg        <= cnt_next;
        num_x_reg      <= num_x_next;
        num_y_reg      <= num_y_next;
        dr_x_reg       <= dr_x_next;
        dr_y_reg       <= dr_y_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_colour_reg <= out_colour_next;
        out_write_reg  <= out_write_next;
        out_last_reg   <= out_last_next;
        out_busy_reg   <= out_busy_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_pixel_x      = out_x_reg;
    assign m_pixel_y      = out_y_reg;
    assign m_pixel_colour = out_colour_reg;
    assign m_pixel_write  = out_write_reg;
    assign m_line_last    = out_last_reg;
    assign m_line_busy    = out_busy_reg;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the DDA line rasterizer: directed table, then random line traffic.
// Depends on drl_pkg and the dda_line_rasterizer top level; the model of the block is built in.
`default_nettype none
module tb_top;
    import drl_pkg::*;

    // One result transfer as the block presents it on the m_ side.
    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [31:0]        colour;
        logic               write;
        logic               last;
        logic               busy;
    } pixel_t;

    // One row of the directed table. Where has_exp is set, the typed pixel is expected
    // instead of the one that the line model works out.
    typedef struct {
        logic               action;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [23:0] ex;
        logic signed [23:0] ey;
        logic [31:0]        colour;
        bit                 has_exp;
        pixel_t             exp;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_index = CFG_WINDOW_WIDTH;
    logic [14:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = ACTION_LOAD;
    logic signed [23:0] s_start_x = '0;
    logic signed [23:0] s_start_y = '0;
    logic signed [23:0] s_end_x = '0;
    logic signed [23:0] s_end_y = '0;
    logic [31:0]        s_line_colour = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_pixel_x;
    logic signed [15:0] m_pixel_y;
    logic [31:0]        m_pixel_colour;
    logic               m_pixel_write;
    logic               m_line_last;
    logic               m_line_busy;

    dda_line_rasterizer dut (.*);

    always #10 aclk = ~aclk;

    // Copy of the line state, kept in step with every accepted input transfer.
    logic [14:0]     win_w = WIDTH_RESET;
    logic [14:0]     win_h = HEIGHT_RESET;
    longint          pos_x, pos_y, inc_x, inc_y;
    int unsigned     steps_left;
    logic [31:0]     held_colour;

    pixel_t pending_pixels[$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_request = 0;

    // Integer square root by the digit-pair method.
    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= root + b) begin
                s -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic longint div_toward_zero(longint num, int unsigned den);
        longint unsigned mag;
        mag = (num < 0) ? -num : num;
        mag = mag / den;
        return (num < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // The integer part is truncated towards zero, then cut to 16 bits.
    function automatic logic [15:0] whole_part(longint pos);
        longint ip;
        ip = (pos < 0) ? -((-pos) >>> 16) : (pos >>> 16);
        return ip[15:0];
    endfunction

    function automatic bit in_window(longint pos, logic [14:0] bound);
        return pos > 0 && pos < (longint'(bound) <<< 16);
    endfunction

    // Advances the line state by one input item and returns the pixel it yields.
    function automatic pixel_t rasterize(logic act, logic signed [23:0] sx, logic signed [23:0] sy,
                                         logic signed [23:0] ex, logic signed [23:0] ey,
                                         logic [31:0] col);
        pixel_t          p;
        longint          dx, dy;
        longint unsigned len;
        int unsigned     cnt;
        p = '{default: '0};
        if (act == ACTION_LOAD) begin
            dx = longint'(ex) - longint'(sx);
            dy = longint'(ey) - longint'(sy);
            len = int_sqrt(longint'(dx * dx) + longint'(dy * dy)) >> 8;
            cnt = (len > 65535) ? 65535 : int'(len);
            pos_x = longint'(sx) <<< 8;
            pos_y = longint'(sy) <<< 8;
            inc_x = (cnt != 0) ? div_toward_zero(dx <<< 8, cnt) : 0;
            inc_y = (cnt != 0) ? div_toward_zero(dy <<< 8, cnt) : 0;
            steps_left = cnt;
            held_colour = col;
            p.busy = (cnt != 0);
            return p;
        end
        if (steps_left == 0) return p;
        p.px = whole_part(pos_x);
        p.py = whole_part(pos_y);
        p.colour = held_colour;
        p.write = in_window(pos_x, win_w) && in_window(pos_y, win_h);
        pos_x += inc_x;
        pos_y += inc_y;
        steps_left--;
        p.last = (steps_left == 0);
        p.busy = (steps_left != 0);
        return p;
    endfunction

    // Offers one item from the falling edge on and waits for its transfer. Valid is held
    // between back-to-back items, so it is only ever lowered when the sender idles.
    task automatic offer(logic act, logic signed [23:0] sx, logic signed [23:0] sy,
                         logic signed [23:0] ex, logic signed [23:0] ey, logic [31:0] col,
                         bit has_exp = 0, pixel_t exp = '{default: '0});
        pixel_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_action = act;
        s_start_x = sx;
        s_start_y = sy;
        s_end_x = ex;
        s_end_y = ey;
        s_line_colour = col;
        do @(posedge aclk); while (!s_ready);
        p = rasterize(act, sx, sy, ex, ey, col);
        pending_pixels.push_back(has_exp ? exp : p);
        @(negedge aclk);
    endtask

    task automatic tick();
        offer(ACTION_TICK, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), $urandom);
    endtask

    // Lowers valid and lets every expected pixel arrive, then idles before the next phase.
    task automatic drain();
        s_valid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_window(logic [14:0] w, logic [14:0] h);
        cfg_write = 1'b1;
        cfg_index = CFG_WINDOW_WIDTH;
        cfg_data = w;
        @(negedge aclk);
        cfg_index = CFG_WINDOW_HEIGHT;
        cfg_data = h;
        @(negedge aclk);
        cfg_write = 1'b0;
        win_w = w;
        win_h = h;
    endtask

    function automatic logic signed [23:0] coord_near(int hi_px);
        return 24'(int'($urandom_range(0, (hi_px + 40) * 256)) - 20 * 256);
    endfunction

    // Mostly whole lines with random content: a short load, then its ticks and a few spare
    // ones. The rest is noise: full-range loads, which may saturate, and stray ticks.
    task automatic random_lines(int n_items, int w_px, int h_px);
        int                 sent;
        int                 n_ticks;
        logic signed [23:0] sx, sy;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                sx = coord_near(w_px);
                sy = coord_near(h_px);
                offer(ACTION_LOAD, sx, sy,
                      sx + 24'(int'($urandom_range(0, 2 * 40 * 256)) - 40 * 256),
                      sy + 24'(int'($urandom_range(0, 2 * 40 * 256)) - 40 * 256), $urandom);
                n_ticks = steps_left + $urandom_range(0, 2);
                // Now and then the line is cut short by the next load.
                if ($urandom_range(9) == 0) n_ticks = $urandom_range(0, n_ticks);
            end else if ($urandom_range(1) == 0) begin
                offer(ACTION_LOAD, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      $urandom);
                n_ticks = $urandom_range(0, 5);
            end else begin
                n_ticks = 1;
                sent--;
            end
            sent += 1 + n_ticks;
            repeat (n_ticks) tick();
        end
    endtask

    // The receiver stalls at random; on request it holds off for a long stretch so that the
    // queue fills and the input side stalls.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 0;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Each result transfer is matched against the oldest expected pixel.
    always @(posedge aclk) begin
        pixel_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("result transfer with no pixel expected");
                fail_count++;
            end else begin
                e = pending_pixels.pop_front();
                if (m_pixel_x !== e.px) begin
                    $error("pixel_x: expected %0d, got %0d", e.px, m_pixel_x);
                    fail_count++;
                end
                if (m_pixel_y !== e.py) begin
                    $error("pixel_y: expected %0d, got %0d", e.py, m_pixel_y);
                    fail_count++;
                end
                if (m_pixel_colour !== e.colour) begin
                    $error("pixel_colour: expected %h, got %h", e.colour, m_pixel_colour);
                    fail_count++;
                end
                if (m_pixel_write !== e.write) begin
                    $error("pixel_write: expected %b, got %b", e.write, m_pixel_write);
                    fail_count++;
                end
                if (m_line_last !== e.last) begin
                    $error("line_last: expected %b, got %b", e.last, m_line_last);
                    fail_count++;
                end
                if (m_line_busy !== e.busy) begin
                    $error("line_busy: expected %b, got %b", e.busy, m_line_busy);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        row_t   rows[$];
        pixel_t none;
        pixel_t busy_only;
        none = '{default: '0};
        busy_only = '{default: '0};
        busy_only.busy = 1'b1;
        steps_left = 0;
        pos_x = 0; pos_y = 0; inc_x = 0; inc_y = 0;
        held_colour = '0;

        // Directed cases: an idle tick, a zero-length line, the full-range diagonal that
        // saturates the count, an ordinary line walked to its end, and a load that
        // replaces a line still in progress.
        rows = '{
            '{ACTION_TICK, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 32'hFFFFFFFF, 1, none},
            '{ACTION_LOAD, 24'h001000, 24'h002000, 24'h001000, 24'h002000, 32'hA5A5A5A5, 1, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 1, none},
            '{ACTION_LOAD, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 32'hFFFFFFFF, 1,
              busy_only},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 1,
              '{16'sh8000, 16'sh8000, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b1}},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_LOAD, 24'h7FFFFF, 24'h000000, 24'h800000, 24'h7FFFFF, 32'h00000001, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_LOAD, 24'h000180, 24'h000280, 24'h000580, 24'h000080, 32'h12345678, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_LOAD, 24'hFFF800, 24'h000100, 24'h078000, 24'h043800, 32'hCAFEF00D, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_LOAD, 24'h000100, 24'h000100, 24'h000100, 24'h000400, 32'h0F0F0F0F, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none},
            '{ACTION_TICK, 24'h0, 24'h0, 24'h0, 24'h0, 32'h0, 0, none}
        };

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // The directed table runs at the reset window, with no idling on either side.
        foreach (rows[i])
            offer(rows[i].action, rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey,
                  rows[i].colour, rows[i].has_exp, rows[i].exp);
        drain();

        // One-pixel window: only positions between zero and one pixel are drawn.
        write_window(15'd1, 15'd1);
        send_idle_pct = 24;
        recv_idle_pct = 75;
        random_lines(400, 4, 4);
        drain();

        // Largest window; the short lines are kept clear of the edge of the coordinate
        // range so that no endpoint wraps round into a full-range line.
        write_window(15'd32767, 15'd32767);
        send_idle_pct = 75;
        recv_idle_pct = 24;
        random_lines(400, 32000, 32000);
        drain();

        // No idling, with one long hold-off on the result side early in the phase.
        write_window(15'd640, 15'd480);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1;
        random_lines(400, 640, 480);
        drain();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
